// File: hw/rtl/ncd_pkg.sv
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared types, constants and codes of the nearest codeword decoder.
// ----------------------------------------------------------------------------
package ncd_pkg;

    localparam int MAX_CODEWORDS = 256;
    localparam int MAX_LENGTH    = 64;
    localparam int ADDR_W        = $clog2(MAX_CODEWORDS);

    localparam int WORD_W  = 64;
    localparam int IDX_W   = 8;
    localparam int LEN_W   = 7;
    localparam int SIZE_W  = 9;
    localparam int CFG_W   = 9;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(MAX_LENGTH);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_CODEWORDS);

    localparam logic CFG_CODE_LENGTH   = 1'b0;
    localparam logic CFG_CODEBOOK_SIZE = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  entry_index;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  sent_index;
    } in_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] decoded_index;
        logic [LEN_W-1:0] agreements;
        logic             exact_match;
        logic             word_error;
    } out_rsp_t;

    typedef struct packed {
        logic              load_entry;
        logic              take_decode;
        logic              rd_en;
        logic              rd_sent;
        logic              rd_last;
        logic [ADDR_W-1:0] scan_idx;
        logic              out_load;
    } ncd_cmd_t;

    typedef struct packed {
        logic search_done;
        logic out_free;
    } ncd_sts_t;

endpackage

// File: hw/rtl/ncd_ctrl.sv
// ----------------------------------------------------------------------------
// ncd_ctrl
// Sequencer: accepts requests, scans the codebook addresses, hands off result.
// ----------------------------------------------------------------------------
module ncd_ctrl
    import ncd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    input  logic [ADDR_W-1:0] last_idx,
    input  ncd_sts_t          sts,
    output ncd_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SENT = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic              accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmd              = '0;
        cmd.scan_idx     = idx_reg;
        cmd.load_entry   = accept && (in_kind == KIND_LOAD);
        cmd.take_decode  = accept && (in_kind == KIND_DECODE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.take_decode)
                begin
                    state_next = ST_SENT;
                end
            end
            ST_SENT:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sent = 1'b1;
                idx_next    = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.search_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_last = (idx_reg == last_idx);
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_WAIT:
            begin
                if (sts.search_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// File: hw/rtl/ncd_dp.sv
// ----------------------------------------------------------------------------
// ncd_dp
// Datapath: codebook memory, agreement count pipeline, best tracking, output.
// ----------------------------------------------------------------------------
module ncd_dp
    import ncd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ncd_cmd_t          cmd,
    output ncd_sts_t          sts,
    input  in_req_t           in_req,
    input  logic [WORD_W-1:0] mask,
    input  logic [LEN_W-1:0]  len,
    output logic              out_valid,
    input  logic              out_ready,
    output out_rsp_t          out_rsp
);

    localparam int NPART = WORD_W / 8;

    logic [WORD_W-1:0] mem [MAX_CODEWORDS];

    logic [WORD_W-1:0] word_reg;
    logic [ADDR_W-1:0] sent_reg;
    logic [WORD_W-1:0] sent_word_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic              rd_valid_reg;
    logic              rd_sent_reg;
    logic              rd_last_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [WORD_W-1:0] rdata_reg;

    logic              part_valid_reg;
    logic              part_last_reg;
    logic [ADDR_W-1:0] part_idx_reg;
    logic [WORD_W-1:0] part_word_reg;
    logic [3:0]        part_cnt_reg [NPART];
    logic [3:0]        part_cnt_next [NPART];
    logic [WORD_W-1:0] agree_bits;

    logic              cnt_valid_reg;
    logic              cnt_last_reg;
    logic [ADDR_W-1:0] cnt_idx_reg;
    logic [WORD_W-1:0] cnt_word_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;

    logic [ADDR_W-1:0] best_idx_reg;
    logic [LEN_W-1:0]  best_cnt_reg;
    logic [WORD_W-1:0] best_word_reg;

    logic              better;
    logic              kill;
    logic              out_valid_reg;
    out_rsp_t          out_rsp_reg;

    assign rd_addr    = cmd.rd_sent ? sent_reg : cmd.scan_idx;
    assign agree_bits = ~(word_reg ^ rdata_reg) & mask;
    assign better     = (cnt_idx_reg == '0) || (cnt_reg > best_cnt_reg);
    assign kill       = cnt_valid_reg && ((cnt_reg == len) || cnt_last_reg);

    assign sts.search_done = kill;
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            mem[in_req.entry_index[ADDR_W-1:0]] <= in_req.word;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        for (int p = 0; p < NPART; p++)
        begin
            part_cnt_next[p] = '0;
            for (int b = 0; b < 8; b++)
            begin
                part_cnt_next[p] = part_cnt_next[p] + 4'(agree_bits[p*8+b]);
            end
        end
    end

    always_comb
    begin
        cnt_next = '0;
        for (int p = 0; p < NPART; p++)
        begin
            cnt_next = cnt_next + LEN_W'(part_cnt_reg[p]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            part_valid_reg <= 1'b0;
            cnt_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.rd_en && !kill;
            part_valid_reg <= rd_valid_reg && !rd_sent_reg && !kill;
            cnt_valid_reg  <= part_valid_reg && !kill;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_decode)
        begin
            word_reg <= in_req.word;
            sent_reg <= in_req.sent_index[ADDR_W-1:0];
        end
        rd_sent_reg <= cmd.rd_sent;
        rd_last_reg <= cmd.rd_last;
        rd_idx_reg  <= cmd.scan_idx;
        if (rd_valid_reg && rd_sent_reg)
        begin
            sent_word_reg <= rdata_reg;
        end
        part_last_reg <= rd_last_reg;
        part_idx_reg  <= rd_idx_reg;
        part_word_reg <= rdata_reg;
        part_cnt_reg  <= part_cnt_next;
        cnt_last_reg  <= part_last_reg;
        cnt_idx_reg   <= part_idx_reg;
        cnt_word_reg  <= part_word_reg;
        cnt_reg       <= cnt_next;
        if (cnt_valid_reg && better)
        begin
            best_idx_reg  <= cnt_idx_reg;
            best_cnt_reg  <= cnt_reg;
            best_word_reg <= cnt_word_reg;
        end
        if (cmd.out_load)
        begin
            out_rsp_reg.decoded_index <= IDX_W'(best_idx_reg);
            out_rsp_reg.agreements    <= best_cnt_reg;
            out_rsp_reg.exact_match   <= (best_cnt_reg == len);
            out_rsp_reg.word_error    <= |((best_word_reg ^ sent_word_reg) & mask);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

// File: hw/rtl/nearest_codeword_decoder.sv
// ----------------------------------------------------------------------------
// nearest_codeword_decoder
// Minimum Hamming distance search over a loadable 256 x 64 codebook.
//
//   channel   signals                        direction
//   request   in_valid / in_ready / in_req   into the block
//   result    out_valid / out_ready / out_rsp out of the block
//   config    cfg_we / cfg_idx / cfg_data    into the block, write only
//
// A load request writes the codebook on acceptance; in_ready stays high. A decode
// result goes valid after the sent-word read, one memory read per entry, two count
// stages, final compare and output load; in_ready returns with out_valid.
// An exact match ends the scan early.
// Asynchronous active-low reset clears control state; the codebook is not cleared.
// A stalled result holds in the output register; the next decode holds its result.
// ----------------------------------------------------------------------------
module nearest_codeword_decoder
    import ncd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_req_t          in_req,
    output logic             out_valid,
    input  logic             out_ready,
    output out_rsp_t         out_rsp,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [LEN_W-1:0]  code_length_reg;
    logic [SIZE_W-1:0] codebook_size_reg;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] mask;
    logic [ADDR_W-1:0] last_idx;
    ncd_cmd_t          cmd;
    ncd_sts_t          sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg   <= LEN_RESET;
            codebook_size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_CODE_LENGTH:   code_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_CODEBOOK_SIZE: codebook_size_reg <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (code_length_reg > LEN_W'(MAX_LENGTH))
        begin
            len = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            len = code_length_reg;
        end
        if (len >= LEN_W'(WORD_W))
        begin
            mask = '1;
        end
        else
        begin
            mask = (WORD_W'(1) << len) - WORD_W'(1);
        end
        priority if (codebook_size_reg == '0)
        begin
            last_idx = '0;
        end
        else if (codebook_size_reg > SIZE_W'(MAX_CODEWORDS))
        begin
            last_idx = ADDR_W'(MAX_CODEWORDS - 1);
        end
        else
        begin
            last_idx = ADDR_W'(codebook_size_reg - SIZE_W'(1));
        end
    end

    ncd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_req.kind),
        .in_ready (in_ready),
        .last_idx (last_idx),
        .sts      (sts),
        .cmd      (cmd)
    );

    ncd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_req    (in_req),
        .mask      (mask),
        .len       (len),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

endmodule

// File: hw/rtl/ncd_checker.sv
// ----------------------------------------------------------------------------
// ncd_checker
// Port-level checks of the nearest codeword decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ncd_checker
    import ncd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input in_req_t  in_req,
    input logic     out_valid,
    input logic     out_ready,
    input out_rsp_t out_rsp
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rsp))
        else $error("result changed while stalled");

    a_agree_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rsp.agreements <= LEN_W'(MAX_LENGTH))
        else $error("agreement count out of range");

    a_full_exact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_rsp.agreements == LEN_W'(MAX_LENGTH)) |-> out_rsp.exact_match)
        else $error("full agreement not flagged exact");

    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_req.kind == KIND_DECODE) |=> !in_ready)
        else $error("request taken during a decode");

endmodule

bind nearest_codeword_decoder ncd_checker u_ncd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest codeword decoder. It fills the whole
// codebook, then runs directed and random decode requests under several
// code length and codebook size settings. Requests are drawn mostly as noisy
// copies of stored codewords. Both handshakes stall in random bursts. Every
// result is compared field by field against an in-bench minimum distance
// search over a shadow codebook.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ncd_pkg::*;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_req_t          in_req   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_rsp_t         out_rsp;
    logic             cfg_we   = 1'b0;
    logic             cfg_idx  = CFG_CODE_LENGTH;
    logic [CFG_W-1:0] cfg_data = '0;

    in_req_t           pending_requests[$];
    out_rsp_t          expected_decodes[$];
    logic [WORD_W-1:0] shadow_book[MAX_CODEWORDS];
    logic [WORD_W-1:0] gen_book[MAX_CODEWORDS];
    logic [LEN_W-1:0]  len_reg  = LEN_RESET;
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;

    bit quiet = 1'b0;
    int send_gap;
    int recv_stall;
    int mismatches;
    int decodes_checked;
    int loads_taken;
    int exact_seen;
    int error_seen;
    int settings_used;

    nearest_codeword_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int active_length();
        return (len_reg > MAX_LENGTH) ? MAX_LENGTH : int'(len_reg);
    endfunction

    function automatic int active_size();
        if (size_reg == 0)
            return 1;
        return (size_reg > MAX_CODEWORDS) ? MAX_CODEWORDS : int'(size_reg);
    endfunction

    function automatic logic [WORD_W-1:0] length_mask(input int len);
        return (len >= WORD_W) ? '1 : ((64'd1 << len) - 64'd1);
    endfunction

    function automatic out_rsp_t nearest_entry(input logic [WORD_W-1:0] rx,
                                               input logic [IDX_W-1:0]  sent);
        out_rsp_t          r;
        int                len;
        int                size;
        logic [WORD_W-1:0] mask;
        int                best;
        int                best_cnt;
        int                cnt;
        len      = active_length();
        size     = active_size();
        mask     = length_mask(len);
        best     = 0;
        best_cnt = $countones(~(rx ^ shadow_book[0]) & mask);
        for (int i = 1; i < size && best_cnt != len; i++)
        begin
            cnt = $countones(~(rx ^ shadow_book[i]) & mask);
            if (cnt > best_cnt)
            begin
                best_cnt = cnt;
                best     = i;
            end
        end
        r.decoded_index = IDX_W'(best);
        r.agreements    = LEN_W'(best_cnt);
        r.exact_match   = (best_cnt == len);
        r.word_error    = |((shadow_book[best] ^ shadow_book[sent]) & mask);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic    nv;
        in_req_t nr;
        int      ng;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_req   <= '0;
            send_gap <= 0;
        end
        else
        begin
            nv = in_valid;
            nr = in_req;
            ng = send_gap;
            if (in_valid && in_ready)
            begin
                if (in_req.kind == KIND_LOAD)
                begin
                    shadow_book[in_req.entry_index] = in_req.word;
                    loads_taken++;
                end
                else
                    expected_decodes.push_back(nearest_entry(in_req.word, in_req.sent_index));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (ng > 0)
                    ng--;
                else if (pending_requests.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 7) == 0)
                        ng = $urandom_range(1, 16);
                    else
                    begin
                        nr = pending_requests.pop_front();
                        nv = 1'b1;
                    end
                end
            end
            in_valid <= nv;
            in_req   <= nr;
            send_gap <= ng;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_rsp_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_decodes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", out_rsp);
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    decodes_checked++;
                    if (want.exact_match)
                        exact_seen++;
                    if (want.word_error)
                        error_seen++;
                    if (out_rsp.decoded_index !== want.decoded_index ||
                        out_rsp.agreements !== want.agreements ||
                        out_rsp.exact_match !== want.exact_match ||
                        out_rsp.word_error !== want.word_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected idx=%0d agr=%0d ex=%0b err=%0b,",
                                     want.decoded_index, want.agreements,
                                     want.exact_match, want.word_error,
                                     " got idx=%0d agr=%0d ex=%0b err=%0b",
                                     out_rsp.decoded_index, out_rsp.agreements,
                                     out_rsp.exact_match, out_rsp.word_error);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_stall <= $urandom_range(1, 16);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_load(input int slot, input logic [WORD_W-1:0] w);
        in_req_t r;
        r             = '0;
        r.kind        = KIND_LOAD;
        r.entry_index = IDX_W'(slot);
        r.word        = w;
        r.sent_index  = IDX_W'($urandom);
        gen_book[slot] = w;
        pending_requests.push_back(r);
    endtask

    task automatic push_decode(input logic [WORD_W-1:0] w, input int sent);
        in_req_t r;
        r             = '0;
        r.kind        = KIND_DECODE;
        r.entry_index = IDX_W'($urandom);
        r.word        = w;
        r.sent_index  = IDX_W'(sent);
        pending_requests.push_back(r);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_decodes.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CODE_LENGTH)
            len_reg = LEN_W'(value);
        else
            size_reg = SIZE_W'(value);
    endtask

    task automatic apply_setting(input int len, input int size);
        drain();
        write_reg(CFG_CODE_LENGTH, len);
        write_reg(CFG_CODEBOOK_SIZE, size);
        settings_used++;
    endtask

    task automatic random_phase(input int count);
        int                len;
        int                size;
        int                target;
        int                sent;
        int                flips;
        int                pick;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] w;
        len  = active_length();
        size = active_size();
        mask = length_mask(len);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                target = ($urandom_range(0, 3) != 0) ? $urandom_range(0, size - 1)
                                                     : $urandom_range(0, MAX_CODEWORDS - 1);
                case ($urandom_range(0, 3))
                    0, 1: w = {$urandom, $urandom};
                    2: w = gen_book[$urandom_range(0, MAX_CODEWORDS - 1)];
                    default: w = gen_book[$urandom_range(0, MAX_CODEWORDS - 1)]
                                 ^ (64'd1 << $urandom_range(0, WORD_W - 1));
                endcase
                push_load(target, w);
            end
            else if (pick < 27)
                push_decode({$urandom, $urandom}, $urandom_range(0, MAX_CODEWORDS - 1));
            else
            begin
                target = $urandom_range(0, size - 1);
                sent   = ($urandom_range(0, 3) != 0) ? target
                                                     : $urandom_range(0, MAX_CODEWORDS - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2: flips = 0;
                    3, 4, 5, 6, 7: flips = $urandom_range(1, 3);
                    default: flips = $urandom_range(4, 4 + len / 2);
                endcase
                w = gen_book[target];
                if (len > 0)
                    for (int k = 0; k < flips; k++)
                        w[$urandom_range(0, len - 1)] ^= 1'b1;
                w = (w & mask) | ({$urandom, $urandom} & ~mask);
                push_decode(w, sent);
            end
        end
    endtask

    initial
    begin
        int len;
        int size;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(MAX_LENGTH, MAX_CODEWORDS);
        for (int i = 0; i < MAX_CODEWORDS; i++)
        begin
            case (i)
                0: push_load(i, 64'd0);
                1: push_load(i, '1);
                2: push_load(i, 64'h5555_5555_5555_5555);
                3: push_load(i, 64'hAAAA_AAAA_AAAA_AAAA);
                default: push_load(i, {$urandom, $urandom});
            endcase
        end

        push_decode(64'd0, 0);
        push_decode('1, 0);
        push_decode(gen_book[255], 255);
        push_decode(gen_book[255] ^ 64'h8000_0000_0000_0000, 255);
        push_decode(64'h5555_5555_5555_5554, 2);
        push_decode(64'h8000_0000_0000_0000, 3);
        push_decode({$urandom, $urandom}, 128);
        push_load(254, gen_book[200]);
        push_decode(gen_book[200] ^ 64'h10, 254);
        push_load(255, '1);
        push_decode('1, 255);
        push_decode(64'hFFFF_FFFF_0000_0000, 1);
        push_decode(gen_book[128], 0);
        drain();
        push_load(254, {$urandom, $urandom});
        push_load(255, {$urandom, $urandom});

        apply_setting(0, 0);
        random_phase(40);
        apply_setting(1, 1);
        random_phase(40);
        apply_setting(127, 511);
        random_phase(40);
        apply_setting(65, 257);
        random_phase(40);
        apply_setting(1, 256);
        random_phase(40);
        apply_setting(64, 1);
        random_phase(40);
        apply_setting(8, 2);
        random_phase(40);
        apply_setting(3, 40);
        random_phase(40);
        apply_setting(64, 256);
        random_phase(40);

        for (int p = 0; p < 30; p++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = MAX_LENGTH;
                4, 5: len = $urandom_range(1, 8);
                6: len = $urandom_range(65, 127);
                default: len = $urandom_range(0, MAX_LENGTH);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: size = $urandom_range(1, 32);
                7, 8: size = $urandom_range(33, 128);
                default: size = $urandom_range(129, 511);
            endcase
            apply_setting(len, size);
            if (p == 29)
                quiet = 1'b1;
            random_phase(40);
        end
        drain();

        while (expected_decodes.size() != 0)
        begin
            void'(expected_decodes.pop_front());
            mismatches++;
        end
        $display("Checked %0d decodes (%0d exact, %0d word errors) and %0d codebook loads",
                 decodes_checked, exact_seen, error_seen, loads_taken);
        $display("across %0d length/size settings; %0d mismatches", settings_used, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
